// File: design/cdtd_pkg.sv
// Shared types and constants for the civil date to day number converter.
// Holds stage payload structs, calendar constants and the March-based day-of-year table.
// No dependencies.
package cdtd_pkg;

    localparam int YEAR_W      = 12;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int HOUR_W      = 5;
    localparam int MINUTE_W    = 6;
    localparam int OFFSET_W    = 7;
    localparam int DAYNUM_W    = 21;

    localparam int YADJ_W      = YEAR_W + 1;   // year after March shift, signed -1..4095
    localparam int DOY_W       = 10;           // signed day of year -1..397
    localparam int MOD_W       = 13;           // signed minute of day plus offset
    localparam int ERA_W       = 5;            // signed era -1..10
    localparam int YOE_W       = 9;            // year of era 0..399
    localparam int DOE_W       = 19;           // signed day of era
    localparam int DELTA_W     = 2;            // signed day carry -1..1

    localparam int YEARS_PER_ERA = 400;
    localparam int DAYS_PER_ERA  = 146097;
    localparam int EPOCH_SHIFT   = 719468;
    localparam int MIN_PER_DAY   = 1440;
    localparam int MIN_PER_HOUR  = 60;
    localparam int MIN_PER_STEP  = 15;
    localparam int DAYS_PER_YEAR = 365;

    // floor(y / 400) == (y * ERA_RECIP) >> ERA_SHIFT for 0 <= y < 4096
    localparam int ERA_RECIP   = 10486;
    localparam int ERA_RECIP_W = 14;
    localparam int ERA_SHIFT   = 22;

    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 48;

    // (153 * mp + 2) / 5 indexed by raw month, mp = month - 3 or month + 9
    localparam logic [8:0] DOY_BASE [16] = '{
        9'd275, 9'd306, 9'd337, 9'd0,   9'd31,  9'd61,  9'd92,  9'd122,
        9'd153, 9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337, 9'd367
    };

    typedef struct packed {
        logic signed [YADJ_W-1:0] year_adj;
        logic signed [DOY_W-1:0]  doy;
        logic signed [MOD_W-1:0]  min_of_day;
    } prep_t;

    typedef struct packed {
        logic [YOE_W-1:0]            yoe;
        logic signed [DAYNUM_W-1:0]  era_base;
        logic signed [DOY_W-1:0]     doy;
        logic signed [DELTA_W-1:0]   delta;
    } era_t;

    typedef struct packed {
        logic signed [DAYNUM_W-1:0] utc_day_number;
        logic signed [DAYNUM_W-1:0] local_day_number;
    } result_t;

endpackage

// File: design/cdtd_prep.sv
// Front stage: March year shift, day of year and minute of day with zone offset.
// Depends on cdtd_pkg.
module cdtd_prep
    import cdtd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [YEAR_W-1:0]          year,
    input  logic [MONTH_W-1:0]         month,
    input  logic [DAY_W-1:0]           day_of_month,
    input  logic [HOUR_W-1:0]          hour,
    input  logic [MINUTE_W-1:0]        minute,
    input  logic signed [OFFSET_W-1:0] offset,
    output logic                       out_valid,
    input  logic                       out_ready,
    output prep_t                      out_data
);

    logic  valid_reg;
    prep_t data_reg;
    prep_t data_next;
    logic  en;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        // months 0..2 belong to the previous March-based year
        if (month <= MONTH_W'(2))
            data_next.year_adj = $signed({1'b0, year}) - YADJ_W'(1);
        else
            data_next.year_adj = $signed({1'b0, year});
        data_next.doy = $signed({1'b0, DOY_BASE[month]})
                      + $signed(DOY_W'(day_of_month)) - DOY_W'(1);
        data_next.min_of_day = $signed(MOD_W'(hour)) * MOD_W'(MIN_PER_HOUR)
                             + $signed(MOD_W'(minute))
                             + MOD_W'(offset) * MOD_W'(MIN_PER_STEP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: design/cdtd_era.sv
// Era stages: era by reciprocal multiply, then year of era and era day base.
// Also resolves the local day carry. Depends on cdtd_pkg.
module cdtd_era
    import cdtd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  prep_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output era_t  out_data
);

    localparam int PROD_W = YEAR_W + ERA_RECIP_W;
    localparam int BASE_W = DAYNUM_W + 1;

    logic                       v1_reg;
    logic signed [YADJ_W-1:0]   year_reg;
    logic signed [ERA_W-1:0]    era_reg;
    logic signed [ERA_W-1:0]    era_next;
    logic signed [DOY_W-1:0]    doy_reg;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic signed [DELTA_W-1:0]  delta_next;
    logic [PROD_W-1:0]          prod;

    logic  v2_reg;
    era_t  data_reg;
    era_t  data_next;
    logic signed [BASE_W-1:0]   base_wide;
    logic signed [YADJ_W-1:0]   yoe_wide;

    logic en1;
    logic en2;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        prod = PROD_W'(in_data.year_adj[YEAR_W-1:0]) * PROD_W'(ERA_RECIP);
        if (in_data.year_adj < 0)
            era_next = -ERA_W'(1);
        else
            era_next = $signed(ERA_W'(prod >> ERA_SHIFT));
        // offset can push the minute count at most one day either way
        if (in_data.min_of_day < 0)
            delta_next = -DELTA_W'(1);
        else if (in_data.min_of_day >= MOD_W'(MIN_PER_DAY))
            delta_next = DELTA_W'(1);
        else
            delta_next = '0;
    end

    always_comb
    begin
        yoe_wide  = year_reg - YADJ_W'(era_reg) * YADJ_W'(YEARS_PER_ERA);
        base_wide = BASE_W'(era_reg) * BASE_W'(DAYS_PER_ERA) - BASE_W'(EPOCH_SHIFT);
        data_next.yoe      = yoe_wide[YOE_W-1:0];
        data_next.era_base = base_wide[DAYNUM_W-1:0];
        data_next.doy      = doy_reg;
        data_next.delta    = delta_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            year_reg  <= in_data.year_adj;
            era_reg   <= era_next;
            doy_reg   <= in_data.doy;
            delta_reg <= delta_next;
        end
        if (en2 && v1_reg)
            data_reg <= data_next;
    end

    assign out_valid = v2_reg;
    assign out_data  = data_reg;

endmodule

// File: design/cdtd_sum.sv
// Summing stages: day of era from year of era, then the final day numbers.
// Second stage is the output register. Depends on cdtd_pkg.
module cdtd_sum
    import cdtd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  era_t    in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic                       v1_reg;
    logic signed [DOE_W-1:0]    doe_reg;
    logic signed [DOE_W-1:0]    doe_next;
    logic signed [DAYNUM_W-1:0] base_reg;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic [1:0]                 centuries;

    logic    v2_reg;
    result_t data_reg;
    result_t data_next;

    logic en1;
    logic en2;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        centuries = 2'(in_data.yoe >= YOE_W'(100)) + 2'(in_data.yoe >= YOE_W'(200))
                  + 2'(in_data.yoe >= YOE_W'(300));
        doe_next = $signed(DOE_W'(in_data.yoe) * DOE_W'(DAYS_PER_YEAR))
                 + $signed(DOE_W'(in_data.yoe >> 2))
                 - $signed(DOE_W'(centuries))
                 + DOE_W'(in_data.doy);
    end

    always_comb
    begin
        data_next.utc_day_number   = base_reg + DAYNUM_W'(doe_reg);
        data_next.local_day_number = base_reg + DAYNUM_W'(doe_reg) + DAYNUM_W'(delta_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            doe_reg   <= doe_next;
            base_reg  <= in_data.era_base;
            delta_reg <= in_data.delta;
        end
        if (en2 && v1_reg)
            data_reg <= data_next;
    end

    assign out_valid = v2_reg;
    assign out_data  = data_reg;

endmodule

// File: design/civil_date_to_day_number.sv
// Civil date to day number converter, top level.
// Items pass through five pipeline stages, in cdtd_prep, cdtd_era and cdtd_sum.
// Throughput is one item per cycle while m_tready holds; each stage holds under stall and bubbles close up.
// Reset clears all stage valid bits and sets the zone offset to zero.
// Depends on cdtd_pkg, cdtd_prep, cdtd_era and cdtd_sum.
module civil_date_to_day_number
    import cdtd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // year[11:0], month[15:12], day_of_month[20:16], hour[25:21], minute[31:26]
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // utc_day_number[20:0], local_day_number[41:21], zero fill[47:42]
    output logic [TDATA_OUT_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [OFFSET_W-1:0]    cfg_data
);

    logic signed [OFFSET_W-1:0] offset_reg;

    logic    prep_valid;
    logic    prep_ready;
    prep_t   prep_data;
    logic    era_valid;
    logic    era_ready;
    era_t    era_data;
    result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else if (cfg_valid)
            offset_reg <= $signed(cfg_data);
    end

    cdtd_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .year         (s_tdata[11:0]),
        .month        (s_tdata[15:12]),
        .day_of_month (s_tdata[20:16]),
        .hour         (s_tdata[25:21]),
        .minute       (s_tdata[31:26]),
        .offset       (offset_reg),
        .out_valid    (prep_valid),
        .out_ready    (prep_ready),
        .out_data     (prep_data)
    );

    cdtd_era u_era (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (era_valid),
        .out_ready (era_ready),
        .out_data  (era_data)
    );

    cdtd_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (era_valid),
        .in_ready  (era_ready),
        .in_data   (era_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tdata = {{(TDATA_OUT_W - 2*DAYNUM_W){1'b0}},
                      result.local_day_number, result.utc_day_number};

`ifndef SYNTHESIS
    logic signed [DAYNUM_W-1:0] day_gap;
    assign day_gap = result.local_day_number - result.utc_day_number;

    // an empty output stage lets every stage advance
    assert property (@(posedge clk) disable iff (!rst_n) !m_tvalid |-> s_tready)
        else $error("input stalled while output stage empty");

    // an accepted item lands in the front stage
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> prep_valid)
        else $error("accepted item lost at front stage");

    // local day stays within one day of the utc day
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (day_gap == 0 || day_gap == 1 || day_gap == -1))
        else $error("local day more than one day from utc day");
`endif

endmodule
